// File: rtl/core/dhfk_pkg.sv
`default_nettype none
package dhfk_pkg;

	localparam int TRIG_FRAC_BITS = 16;
	localparam int CORDIC_STAGES  = 16;
	localparam int AtanCount      = 24;
	localparam int StageW         = $clog2(AtanCount + 1);

	// rotation entries span [-ONE, ONE] in Q.F
	localparam int RotW   = TRIG_FRAC_BITS + 2;
	localparam int PosW   = 32;
	localparam int AngW   = 16;
	localparam int LenW   = 24;
	// cordic x/y need a little headroom past ONE
	localparam int CorW   = TRIG_FRAC_BITS + 3;
	localparam int ZW     = 36;
	// one product term: translation (32) times rotation entry
	localparam int ProdW  = PosW + RotW;
	localparam int AccW   = ProdW + 2;

	localparam logic signed [RotW-1:0] OneQ = RotW'(1) <<< TRIG_FRAC_BITS;
	localparam logic signed [16:0] FullTurn    = 17'sd23040;
	localparam logic signed [16:0] HalfTurn    = 17'sd11520;
	localparam logic signed [16:0] QuarterTurn = 17'sd5760;
	localparam longint GainQ30 = 64'd652032874;
	localparam logic signed [CorW-1:0] StartX =
		CorW'((GainQ30 + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS));

	// atan(2^-i) in units of 2^-22 degree
	function automatic logic signed [ZW-1:0] atan_lut(input logic [StageW-1:0] i);
		logic signed [ZW-1:0] v;
		case (i)
			5'd0:  v = 36'sd188743680;
			5'd1:  v = 36'sd111421900;
			5'd2:  v = 36'sd58872272;
			5'd3:  v = 36'sd29884485;
			5'd4:  v = 36'sd15000234;
			5'd5:  v = 36'sd7507429;
			5'd6:  v = 36'sd3754631;
			5'd7:  v = 36'sd1877430;
			5'd8:  v = 36'sd938729;
			5'd9:  v = 36'sd469366;
			5'd10: v = 36'sd234683;
			5'd11: v = 36'sd117342;
			5'd12: v = 36'sd58671;
			5'd13: v = 36'sd29335;
			5'd14: v = 36'sd14668;
			5'd15: v = 36'sd7334;
			5'd16: v = 36'sd3667;
			5'd17: v = 36'sd1833;
			5'd18: v = 36'sd917;
			5'd19: v = 36'sd458;
			5'd20: v = 36'sd229;
			5'd21: v = 36'sd115;
			5'd22: v = 36'sd57;
			5'd23: v = 36'sd29;
			default: v = '0;
		endcase
		return v;
	endfunction

	// round once: add half, floor shift by F
	function automatic logic signed [AccW-1:0] round_q(input logic signed [AccW-1:0] v);
		logic signed [AccW-1:0] t;
		t = v + (AccW'(1) <<< (TRIG_FRAC_BITS - 1));
		return t >>> TRIG_FRAC_BITS;
	endfunction

	function automatic logic signed [RotW-1:0] sat_rot(input logic signed [AccW-1:0] v);
		logic signed [RotW-1:0] r;
		if (v > AccW'(OneQ))       r = OneQ;
		else if (v < -AccW'(OneQ)) r = -OneQ;
		else                       r = v[RotW-1:0];
		return r;
	endfunction

	function automatic logic signed [PosW-1:0] sat_pos(input logic signed [AccW-1:0] v);
		logic signed [PosW-1:0] r;
		if (v > AccW'(33'sh0_7FFF_FFFF))       r = 32'sh7FFF_FFFF;
		else if (v < -AccW'(33'sh0_8000_0000)) r = 32'sh8000_0000;
		else                                   r = v[PosW-1:0];
		return r;
	endfunction

	// controller to datapath
	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_TRIG_INIT, OP_TRIG_STEP, OP_TRIG_DONE,
		OP_LINK, OP_TRANS, OP_ROT, OP_RESET
	} dp_op_t;

	typedef struct packed {
		dp_op_t          op;
		logic            sel_alpha;
		logic [1:0]      row;
		logic [1:0]      col;
		logic [StageW-1:0] stage;
	} dp_cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/dh_forward_kinematics_unit.sv
// channel | handshake        | payload
// in      | in_valid/in_stall | joint_angle link_twist link_length link_offset last_link
// out     | out_valid/out_stall | pos_x pos_y pos_z
//
// a request runs the shared cordic stage twice, then the row-by-row matrix product
// a last link adds the S_OUT state in which its result is offered
// a result waits in the output registers while out_stall is high; no new
// request is taken until it leaves
// arst_n puts the running transform at identity and zero
`default_nettype none
module dh_forward_kinematics_unit
	import dhfk_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic signed [AngW-1:0] joint_angle,
	input  wire logic signed [AngW-1:0] link_twist,
	input  wire logic signed [LenW-1:0] link_length,
	input  wire logic signed [LenW-1:0] link_offset,
	input  wire logic                   last_link,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic signed [PosW-1:0]      pos_x,
	output logic signed [PosW-1:0]      pos_y,
	output logic signed [PosW-1:0]      pos_z
);

	dp_cmd_t cmd;

	// sequencer: load, two cordic runs, link build, translation rows, rotation entries
	dhfk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.last_link (last_link),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// datapath holds the running transform, which doubles as the output register
	dhfk_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.joint_angle (joint_angle),
		.link_twist  (link_twist),
		.link_length (link_length),
		.link_offset (link_offset),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z)
	);

	// a result and a new request never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("request taken while result pending");

	// a held result does not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pos_x) && $stable(pos_y) && $stable(pos_z))
		else $error("result changed while stalled");

	// after delivery the position is cleared
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> pos_x == 0 && pos_y == 0 && pos_z == 0)
		else $error("transform not reset after result");

endmodule
`default_nettype wire

// File: rtl/core/dhfk_ctrl.sv
`default_nettype none
module dhfk_ctrl
	import dhfk_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	input  wire logic    last_link,
	input  wire logic    out_stall,
	output logic         out_valid,
	output dp_cmd_t      cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_TINIT, S_TSTEP, S_TDONE, S_LINK, S_TRANS, S_ROT, S_OUT
	} state_t;

	state_t            state_q;
	logic              alpha_q;
	logic              last_q;
	logic [1:0]        row_q, col_q;
	logic [StageW-1:0] stage_q;
	localparam logic [StageW-1:0] LastStage =
		StageW'(((CORDIC_STAGES < AtanCount) ? CORDIC_STAGES : AtanCount) - 1);

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '{op: OP_NONE, sel_alpha: alpha_q, row: row_q, col: col_q, stage: stage_q};
		case (state_q)
			S_IDLE:  if (in_valid) cmd.op = OP_LOAD;
			S_TINIT: cmd.op = OP_TRIG_INIT;
			S_TSTEP: cmd.op = OP_TRIG_STEP;
			S_TDONE: cmd.op = OP_TRIG_DONE;
			S_LINK:  cmd.op = OP_LINK;
			S_TRANS: cmd.op = OP_TRANS;
			S_ROT:   cmd.op = OP_ROT;
			S_OUT:   if (!out_stall) cmd.op = OP_RESET;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			alpha_q   <= 1'b0;
			last_q    <= 1'b0;
			row_q     <= '0;
			col_q     <= '0;
			stage_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					last_q  <= last_link;
					alpha_q <= 1'b0;
					state_q <= S_TINIT;
				end
				S_TINIT: begin
					stage_q <= '0;
					state_q <= S_TSTEP;
				end
				S_TSTEP: begin
					if (stage_q == LastStage) state_q <= S_TDONE;
					else stage_q <= stage_q + 1'b1;
				end
				S_TDONE: begin
					if (alpha_q) state_q <= S_LINK;
					else begin
						alpha_q <= 1'b1;
						state_q <= S_TINIT;
					end
				end
				S_LINK: begin
					row_q   <= '0;
					state_q <= S_TRANS;
				end
				S_TRANS: begin
					if (row_q == 2'd2) begin
						row_q   <= '0;
						col_q   <= '0;
						state_q <= S_ROT;
					end else row_q <= row_q + 1'b1;
				end
				S_ROT: begin
					if (col_q == 2'd2) begin
						col_q <= '0;
						if (row_q == 2'd2) begin
							if (last_q) begin
								out_valid <= 1'b1;
								state_q   <= S_OUT;
							end else state_q <= S_IDLE;
						end else row_q <= row_q + 1'b1;
					end else col_q <= col_q + 1'b1;
				end
				S_OUT: if (!out_stall) begin
					out_valid <= 1'b0;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/dhfk_datapath.sv
`default_nettype none
module dhfk_datapath
	import dhfk_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire dp_cmd_t                cmd,
	input  wire logic signed [AngW-1:0] joint_angle,
	input  wire logic signed [AngW-1:0] link_twist,
	input  wire logic signed [LenW-1:0] link_length,
	input  wire logic signed [LenW-1:0] link_offset,
	output logic signed [PosW-1:0]      pos_x,
	output logic signed [PosW-1:0]      pos_y,
	output logic signed [PosW-1:0]      pos_z
);

	logic signed [AngW-1:0] theta_q, alpha_q;
	logic signed [LenW-1:0] len_q, off_q;
	logic signed [CorW-1:0] x_q, y_q;
	logic signed [ZW-1:0]   z_q;
	logic                   flip_q;
	logic signed [RotW-1:0] ct_q, st_q, ca_q, sa_q;
	logic signed [RotW-1:0] a_q [9];
	logic signed [PosW-1:0] p_q [3];
	logic signed [RotW-1:0] rot_q [9];
	logic signed [RotW-1:0] nr_q [9];
	logic signed [PosW-1:0] tr_q [3];

	// angle reduction to [-90, 90] degrees
	logic signed [16:0] ang, r0, r1;
	logic               fl;
	always_comb begin
		ang = cmd.sel_alpha ? 17'(alpha_q) : 17'(theta_q);
		// |angle| <= 2^15 so at most one turn to remove each way
		r0 = ang;
		if (r0 >= FullTurn) r0 = r0 - FullTurn;
		else if (r0 <= -FullTurn) r0 = r0 + FullTurn;
		if (r0 < 0) r0 = r0 + FullTurn;
		if (r0 >= HalfTurn) r0 = r0 - FullTurn;
		fl = 1'b0;
		r1 = r0;
		if (r0 > QuarterTurn) begin
			r1 = r0 - HalfTurn;
			fl = 1'b1;
		end else if (r0 < -QuarterTurn) begin
			r1 = r0 + HalfTurn;
			fl = 1'b1;
		end
	end

	logic signed [CorW-1:0] xs, ys, fx, fy;
	logic signed [RotW-1:0] cx, cy;
	always_comb begin
		xs = x_q >>> cmd.stage;
		ys = y_q >>> cmd.stage;
		fx = flip_q ? -x_q : x_q;
		fy = flip_q ? -y_q : y_q;
		cx = sat_rot(AccW'(fx));
		cy = sat_rot(AccW'(fy));
	end

	function automatic logic signed [RotW-1:0] mq(input logic signed [RotW-1:0] a,
	                                              input logic signed [RotW-1:0] b);
		return sat_rot(round_q(AccW'(a) * AccW'(b)));
	endfunction

	// one row-times-column term set per cycle
	logic signed [AccW-1:0] acc_t, acc_r;
	logic [3:0] ri;
	always_comb begin
		ri = 4'(cmd.row) * 4'd3;
		acc_t = AccW'(rot_q[ri])      * AccW'(p_q[0])
		      + AccW'(rot_q[ri + 4'd1]) * AccW'(p_q[1])
		      + AccW'(rot_q[ri + 4'd2]) * AccW'(p_q[2]);
		acc_r = AccW'(rot_q[ri])      * AccW'(a_q[cmd.col])
		      + AccW'(rot_q[ri + 4'd1]) * AccW'(a_q[4'd3 + 4'(cmd.col)])
		      + AccW'(rot_q[ri + 4'd2]) * AccW'(a_q[4'd6 + 4'(cmd.col)]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) rot_q[i] <= (i % 4 == 0) ? OneQ : '0;
			for (int i = 0; i < 3; i++) tr_q[i] <= '0;
		end else begin
			case (cmd.op)
				OP_TRANS: tr_q[cmd.row] <=
					sat_pos(AccW'(tr_q[cmd.row]) + round_q(acc_t));
				OP_ROT: begin
					nr_q[ri + 4'(cmd.col)] <= sat_rot(round_q(acc_r));
					if (cmd.row == 2'd2 && cmd.col == 2'd2) begin
						for (int i = 0; i < 8; i++) rot_q[i] <= nr_q[i];
						rot_q[8] <= sat_rot(round_q(acc_r));
					end
				end
				OP_RESET: begin
					for (int i = 0; i < 9; i++) rot_q[i] <= (i % 4 == 0) ? OneQ : '0;
					for (int i = 0; i < 3; i++) tr_q[i] <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				theta_q <= joint_angle;
				alpha_q <= link_twist;
				len_q   <= link_length;
				off_q   <= link_offset;
			end
			OP_TRIG_INIT: begin
				x_q    <= StartX;
				y_q    <= '0;
				z_q    <= ZW'(r1) <<< 16;
				flip_q <= fl;
			end
			OP_TRIG_STEP: begin
				if (!z_q[ZW-1]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_lut(cmd.stage);
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_lut(cmd.stage);
				end
			end
			OP_TRIG_DONE: begin
				if (cmd.sel_alpha) begin
					ca_q <= cx;
					sa_q <= cy;
				end else begin
					ct_q <= cx;
					st_q <= cy;
				end
			end
			OP_LINK: begin
				a_q[0] <= ct_q;
				a_q[1] <= -mq(st_q, ca_q);
				a_q[2] <= mq(st_q, sa_q);
				a_q[3] <= st_q;
				a_q[4] <= mq(ct_q, ca_q);
				a_q[5] <= -mq(ct_q, sa_q);
				a_q[6] <= '0;
				a_q[7] <= sa_q;
				a_q[8] <= ca_q;
				p_q[0] <= PosW'(round_q(AccW'(len_q) * AccW'(ct_q)));
				p_q[1] <= PosW'(round_q(AccW'(len_q) * AccW'(st_q)));
				p_q[2] <= PosW'(off_q);
			end
			default: ;
		endcase
	end

	assign pos_x = tr_q[0];
	assign pos_y = tr_q[1];
	assign pos_z = tr_q[2];

endmodule
`default_nettype wire

// File: tb/sv/tb_dh_forward_kinematics_unit.sv
`default_nettype none
module tb_dh_forward_kinematics_unit;
	import dhfk_pkg::*;

	// kinematic chain predictor: running rotation and translation plus pending positions
	class chain_scoreboard;
		longint rot[9];
		longint trans[3];
		longint pending_x[$];
		longint pending_y[$];
		longint pending_z[$];
		int errors;

		function new();
			errors = 0;
			clear_chain();
		endfunction

		function void clear_chain();
			for (int i = 0; i < 9; i++) rot[i] = (i % 4 == 0) ? (64'sd1 << TRIG_FRAC_BITS) : 0;
			for (int i = 0; i < 3; i++) trans[i] = 0;
		endfunction

		static function longint asr(longint v, int n);
			return v >>> n;
		endfunction

		static function longint rnd(longint v);
			return asr(v + (64'sd1 << (TRIG_FRAC_BITS - 1)), TRIG_FRAC_BITS);
		endfunction

		static function longint clip(longint v, longint lo, longint hi);
			if (v < lo) return lo;
			if (v > hi) return hi;
			return v;
		endfunction

		static function longint atan_step(int i);
			longint t[24] = '{188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
				3754631, 1877430, 938729, 469366, 234683, 117342, 58671, 29335, 14668,
				7334, 3667, 1833, 917, 458, 229, 115, 57, 29};
			return t[i];
		endfunction

		static function void trig(longint ang, output longint c, output longint s);
			longint r, x, y, z, nx, one;
			bit flip;
			one = 64'sd1 << TRIG_FRAC_BITS;
			flip = 0;
			r = ang % 23040;
			if (r < 0) r += 23040;
			if (r >= 11520) r -= 23040;
			if (r > 5760) begin
				r -= 11520;
				flip = 1;
			end else if (r < -5760) begin
				r += 11520;
				flip = 1;
			end
			x = asr(64'sd652032874 + (64'sd1 << (29 - TRIG_FRAC_BITS)), 30 - TRIG_FRAC_BITS);
			y = 0;
			z = r * 65536;
			for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
				if (z >= 0) begin
					nx = x - asr(y, i);
					y = y + asr(x, i);
					z -= atan_step(i);
				end else begin
					nx = x + asr(y, i);
					y = y - asr(x, i);
					z += atan_step(i);
				end
				x = nx;
			end
			if (flip) begin
				x = -x;
				y = -y;
			end
			c = clip(x, -one, one);
			s = clip(y, -one, one);
		endfunction

		// fold one accepted link into the chain
		function void note_link(longint th, longint al, longint len, longint off, bit last);
			longint ct, st, ca, sa, one, acc;
			longint a[9], p[3], nr[9];
			one = 64'sd1 << TRIG_FRAC_BITS;
			trig(th, ct, st);
			trig(al, ca, sa);
			a[0] = ct; a[1] = -clip(rnd(st * ca), -one, one); a[2] = clip(rnd(st * sa), -one, one);
			a[3] = st; a[4] = clip(rnd(ct * ca), -one, one); a[5] = -clip(rnd(ct * sa), -one, one);
			a[6] = 0; a[7] = sa; a[8] = ca;
			p[0] = rnd(len * ct);
			p[1] = rnd(len * st);
			p[2] = off;
			for (int i = 0; i < 3; i++) begin
				acc = 0;
				for (int j = 0; j < 3; j++) acc += rot[i*3+j] * p[j];
				trans[i] = clip(trans[i] + rnd(acc), -64'sd2147483648, 64'sd2147483647);
			end
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					acc = rot[i*3] * a[j] + rot[i*3+1] * a[3+j] + rot[i*3+2] * a[6+j];
					nr[i*3+j] = clip(rnd(acc), -one, one);
				end
			for (int i = 0; i < 9; i++) rot[i] = nr[i];
			if (last) begin
				pending_x.push_back(trans[0]);
				pending_y.push_back(trans[1]);
				pending_z.push_back(trans[2]);
				clear_chain();
			end
		endfunction

		function void check_position(longint x, longint y, longint z);
			longint ex, ey, ez;
			if (pending_x.size() == 0) begin
				$error("unexpected position x=%0d y=%0d z=%0d", x, y, z);
				errors++;
				return;
			end
			ex = pending_x.pop_front();
			ey = pending_y.pop_front();
			ez = pending_z.pop_front();
			if (x != ex) begin
				$error("pos_x expected %0d got %0d", ex, x);
				errors++;
			end
			if (y != ey) begin
				$error("pos_y expected %0d got %0d", ey, y);
				errors++;
			end
			if (z != ez) begin
				$error("pos_z expected %0d got %0d", ez, z);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_x.size();
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [AngW-1:0] joint_angle = '0;
	logic signed [AngW-1:0] link_twist = '0;
	logic signed [LenW-1:0] link_length = '0;
	logic signed [LenW-1:0] link_offset = '0;
	logic last_link = 0;
	logic out_valid;
	logic out_stall = 1;
	logic signed [PosW-1:0] pos_x, pos_y, pos_z;

	chain_scoreboard chain = new();
	longint cycle_count = 0;
	bit long_hold = 0;  // requests a long receiver hold-off
	bit offering = 0;   // in_valid has been raised and not yet dropped

	dh_forward_kinematics_unit i_dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog: ~1500 links plus gaps and stalls, taken several times over
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 1500000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// gap length: mostly short, sometimes long
	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0) return $urandom_range(20, 120);
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 4);
	endfunction

	// drop in_valid once the last request has been taken
	task automatic release_input();
		if (offering) begin
			in_valid <= 0;
			offering = 0;
		end
	endtask

	// present one link request and wait until it is taken
	task automatic send_link(logic signed [15:0] th, logic signed [15:0] al,
			logic signed [23:0] len, logic signed [23:0] off, bit last);
		int gap;
		gap = gap_len();
		if (gap > 0) release_input();
		repeat (gap) @(posedge clk);
		in_valid <= 1;
		offering = 1;
		joint_angle <= th;
		link_twist <= al;
		link_length <= len;
		link_offset <= off;
		last_link <= last;
		do @(posedge clk); while (in_stall);
		chain.note_link(th, al, len, off, last);
	endtask

	function automatic logic signed [15:0] rand_angle();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 65535));  // wraps beyond a full turn
			1: return 16'(int'($urandom_range(0, 8)) * 2880 - 11520);  // 45 degree grid
			default: return 16'(int'($urandom_range(0, 46080)) - 23040);
		endcase
	endfunction

	function automatic logic signed [23:0] rand_len();
		case ($urandom_range(0, 4))
			0: return 24'($urandom());  // full range, drives saturation
			1: return ($urandom_range(0, 1)) ? 24'sh7FFFFF : 24'sh800000;
			default: return 24'(int'($urandom_range(0, 20000)) - 10000);
		endcase
	endfunction

	// receiver: random stall with a long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				out_stall <= 1;
				repeat (600) @(posedge clk);
				long_hold = 0;
			end
			n = gap_len();
			if (n > 0) begin
				out_stall <= 1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			chain.check_position(pos_x, pos_y, pos_z);
	end

	initial begin
		int links;
		int sent;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes of every field, wrap, zero chain, saturation
		send_link(16'sd0, 16'sd0, 24'sd0, 24'sd0, 1);
		send_link(16'sd23040, -16'sd23040, 24'sd256, 24'sd256, 1);
		send_link(16'sd5760, 16'sd5760, 24'sd1000, 24'sd500, 0);
		send_link(-16'sd5760, -16'sd11520, 24'sd1000, -24'sd500, 1);
		send_link(16'sd11520, 16'sd2880, 24'sh7FFFFF, 24'sh7FFFFF, 1);
		send_link(16'sh7FFF, 16'sh8000, 24'sh800000, 24'sh800000, 1);
		send_link(16'sh8000, 16'sh7FFF, 24'sh7FFFFF, 24'sh800000, 0);
		send_link(16'shFFFF, 16'sh5555, 24'sh555555, 24'shAAAAAA, 1);
		// repeated max links push translation into saturation
		for (int i = 0; i < 300; i++)
			send_link(16'sd0, 16'sd0, 24'sh7FFFFF, 24'sh7FFFFF, 0);
		send_link(16'sd0, 16'sd0, 24'sh7FFFFF, 24'sh7FFFFF, 1);
		for (int i = 0; i < 300; i++)
			send_link(16'sd11520, 16'sd0, 24'sh7FFFFF, 24'sh800000, 0);
		send_link(16'sd0, 16'sd0, 24'sh0, 24'sh0, 1);

		// sender pauses until the chain is fully drained
		release_input();
		while (chain.outstanding() != 0) @(posedge clk);

		// receiver holds off while links keep coming, block fills and stalls input
		long_hold = 1;
		for (int i = 0; i < 8; i++)
			send_link(rand_angle(), rand_angle(), rand_len(), rand_len(), 1);

		// random chains of 1..6 links
		sent = 0;
		while (sent < 900) begin
			links = $urandom_range(1, 6);
			for (int k = 0; k < links; k++) begin
				send_link(rand_angle(), rand_angle(), rand_len(), rand_len(), k == links - 1);
				sent++;
			end
		end
		release_input();
		while (chain.outstanding() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (chain.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
